### rtl/ttc_pkg.sv
// ============================================================================
// ttc_pkg
// Shared types and constants for the tick timer with countdown interrupt.
// ============================================================================
`default_nettype none

package ttc_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned DivW     = 2;
  localparam int unsigned InUserW  = ReqW + IdxW;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_e;

  typedef enum logic [IdxW-1:0] {
    REG_TIME_HIGH = 2'd0,
    REG_TIME_LOW  = 2'd1,
    REG_COUNTDOWN = 2'd2,
    REG_CONTROL   = 2'd3
  } reg_e;

  // control word bit positions
  localparam int unsigned CtlEnableBit  = 0;
  localparam int unsigned CtlPendingBit = 1;
  localparam int unsigned CtlDivLsb     = 2;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [IdxW-1:0]  reg_index;
    logic [WordW-1:0] write_data;
  } ttc_req_t;

  typedef struct packed {
    logic [WordW-1:0] read_data;
    logic             irq_line;
  } ttc_rsp_t;

endpackage : ttc_pkg

`default_nettype wire

### rtl/ttc_core.sv
// ============================================================================
// ttc_core
// Timer register file and the single-pass update for one item.
// ============================================================================
`default_nettype none

module ttc_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire ttc_pkg::ttc_req_t req_i,
  output      ttc_pkg::ttc_rsp_t rsp_o
);
  import ttc_pkg::*;

  logic [WordW-1:0] time_hi_q, time_hi_d;
  logic [WordW-1:0] time_lo_q, time_lo_d;
  logic [WordW-1:0] count_q, count_d;
  logic [WordW-1:0] reload_q, reload_d;
  logic             enable_q, enable_d;
  logic             pending_q, pending_d;
  logic [DivW-1:0]  div_q, div_d;
  logic [WordW-1:0] rd_data;
  logic [WordW-1:0] ctl_word;

  always_comb begin
    ctl_word                             = '0;
    ctl_word[CtlEnableBit]               = enable_q;
    ctl_word[CtlPendingBit]              = pending_q;
    ctl_word[CtlDivLsb +: DivW]          = div_q;
  end

  always_comb begin
    time_hi_d = time_hi_q;
    time_lo_d = time_lo_q;
    count_d   = count_q;
    reload_d  = reload_q;
    enable_d  = enable_q;
    pending_d = pending_q;
    div_d     = div_q;
    rd_data   = '0;
    unique case (req_i.req_type)
      REQ_TICK: begin
        time_lo_d = time_lo_q + WordW'(1);
        if (&time_lo_q) begin
          time_hi_d = time_hi_q + WordW'(1);
        end
        if (enable_q) begin
          if (count_q == '0) begin
            count_d   = reload_q;
            pending_d = 1'b1;
          end else begin
            count_d = count_q - WordW'(1);
          end
        end
      end
      REQ_READ: begin
        unique case (req_i.reg_index)
          REG_TIME_HIGH: rd_data = time_hi_q;
          REG_TIME_LOW:  rd_data = time_lo_q;
          REG_COUNTDOWN: rd_data = count_q;
          default:       rd_data = ctl_word;
        endcase
      end
      REQ_WRITE: begin
        unique case (req_i.reg_index)
          REG_TIME_HIGH: time_hi_d = req_i.write_data;
          REG_TIME_LOW:  time_lo_d = req_i.write_data;
          REG_COUNTDOWN: begin
            reload_d = req_i.write_data;
            count_d  = req_i.write_data;
          end
          default: begin
            enable_d = req_i.write_data[CtlEnableBit];
            if (req_i.write_data[CtlPendingBit]) begin
              pending_d = 1'b0;
            end
            div_d = req_i.write_data[CtlDivLsb +: DivW];
          end
        endcase
      end
      default: begin
        // unknown request: no state change
      end
    endcase
  end

  assign rsp_o.read_data = rd_data;
  assign rsp_o.irq_line  = pending_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_hi_q <= '0;
      time_lo_q <= '0;
      count_q   <= '0;
      reload_q  <= '0;
      enable_q  <= 1'b0;
      pending_q <= 1'b0;
      div_q     <= '0;
    end else if (en_i) begin
      time_hi_q <= time_hi_d;
      time_lo_q <= time_lo_d;
      count_q   <= count_d;
      reload_q  <= reload_d;
      enable_q  <= enable_d;
      pending_q <= pending_d;
      div_q     <= div_d;
    end
  end

endmodule : ttc_core

`default_nettype wire

### rtl/tick_timer_with_countdown_irq.sv
// ============================================================================
// tick_timer_with_countdown_irq
// Timer peripheral: ticks, register reads and writes, countdown interrupt.
// ============================================================================
//  channel  dir  tuser                          tdata
//  s_axis   in   [1:0] req_type [3:2] reg_index [31:0] write_data
//  m_axis   out  -                              [31:0] read_data [32] irq_line
//
//  One result per item, through the input register, then the register-file
//  update and result register. One item per cycle sustained while m_axis is
//  not stalled; the register-file update in ttc_core is the only loop.
//  Reset clears all timer state and both pipeline valids.
//  A stalled output holds its item; input keeps flowing while the stage
//  ahead can move.
// ============================================================================
`default_nettype none

module tick_timer_with_countdown_irq (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [ttc_pkg::InDataW-1:0]    s_axis_tdata,  // [31:0] write_data
  input  wire logic [ttc_pkg::InUserW-1:0]    s_axis_tuser,  // [1:0] req_type, [3:2] reg_index
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output      logic [ttc_pkg::OutDataW-1:0]   m_axis_tdata   // [31:0] read_data, [32] irq_line
);
  import ttc_pkg::*;

  ttc_req_t in_q, in_d;
  logic     in_vld_q, in_vld_d;
  ttc_rsp_t out_q, rsp;
  logic     out_vld_q, out_vld_d;
  logic     s_acc;
  logic     adv;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_d.req_type   = s_axis_tuser[ReqW-1:0];
    in_d.reg_index  = s_axis_tuser[ReqW +: IdxW];
    in_d.write_data = s_axis_tdata[WordW-1:0];
  end

  assign in_vld_d  = s_acc || (in_vld_q && !adv);
  assign out_vld_d = adv || (out_vld_q && !m_axis_tready);

  ttc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .req_i  (in_q),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q <= in_d;
    end
    if (adv) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - WordW - 1){1'b0}}, out_q.irq_line, out_q.read_data};

endmodule : tick_timer_with_countdown_irq

`default_nettype wire

### rtl/ttc_checker.sv
// ============================================================================
// ttc_checker
// Port-level checks for the tick timer, bound to the top level.
// ============================================================================
`default_nettype none

module ttc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [ttc_pkg::OutDataW-1:0] m_axis_tdata
);
  import ttc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // input only backs up when a result is waiting
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // padding bits above irq_line stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:WordW+1] == '0)
    else $error("nonzero padding in output item");

  // an item accepted while the output is stalled fills both stages, so input stops if the stall goes on
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready
      |=> m_axis_tready || !s_axis_tready)
    else $error("pipeline accepted beyond its depth");

endmodule : ttc_checker

bind tick_timer_with_countdown_irq ttc_checker u_ttc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
